@@ src/fat_datetime_to_unix_seconds_macros.svh @@
// Assertion macros for the exFAT timestamp converter.
// Included by the top level; no other dependencies.
`ifndef FAT_DATETIME_TO_UNIX_SECONDS_MACROS_SVH
`define FAT_DATETIME_TO_UNIX_SECONDS_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FDT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdt assertion failed");
// next-cycle implication
`define FDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdt assertion failed");
`else
`define FDT_ASSERT_NOW(label, clk, rst, ante, cons)
`define FDT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/fdt_pkg.sv @@
// Shared constants and the month-start table for the exFAT timestamp converter.
// No dependencies.
package fdt_pkg;

   localparam logic [15:0] DAYS_PER_YEAR     = 16'd365;
   localparam logic [15:0] EPOCH_GAP_DAYS    = 16'(365 * 10 + 2);
   localparam logic [6:0]  NO_LEAP_YEAR      = 7'd120;
   localparam logic [16:0] SEC_PER_DAY       = 17'd86400;
   localparam logic [16:0] SEC_PER_HOUR      = 17'd3600;
   localparam logic [16:0] SEC_PER_MIN       = 17'd60;
   localparam logic signed [17:0] ZONE_SEC   = 18'sd900;   // 15 minutes
   localparam logic [29:0] NS_PER_CS         = 30'd10000000;
   localparam logic [7:0]  CS_PER_SEC        = 8'd100;

   // days before the first of each month; out-of-range months count none
   function automatic logic [8:0] month_start(input logic [3:0] month);
      logic [8:0] d;
      unique case (month)
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

@@ src/fdt_day_count.sv @@
// Day count since 1970-01-01 from the exFAT date half.
// Uses fdt_pkg.
module fdt_day_count (
   input  logic [6:0]  year_i,    // years since 1980
   input  logic [3:0]  month_i,
   input  logic [4:0]  day_i,
   output logic [15:0] days_o
);

   logic [3:0] month_fix;
   logic [4:0] day_ofs;
   logic [7:0] year_p3;
   logic [5:0] leap_base;
   logic       past_gap;
   logic       cur_leap;
   logic [6:0] leap;

   always_comb begin
      month_fix = (month_i == 4'd0) ? 4'd1 : month_i;
      day_ofs   = (day_i == 5'd0) ? 5'd0 : day_i - 5'd1;
      year_p3   = {1'b0, year_i} + 8'd3;
      leap_base = year_p3[7:2];
      past_gap  = year_i > fdt_pkg::NO_LEAP_YEAR;
      // months 13..15 also count as past February
      cur_leap  = (year_i[1:0] == 2'b00) && (year_i != fdt_pkg::NO_LEAP_YEAR)
                  && (month_fix > 4'd2);
      leap      = {1'b0, leap_base} - {6'b0, past_gap} + {6'b0, cur_leap};
      days_o    = 16'(year_i) * fdt_pkg::DAYS_PER_YEAR + 16'(leap)
                  + 16'(fdt_pkg::month_start(month_fix)) + 16'(day_ofs)
                  + fdt_pkg::EPOCH_GAP_DAYS;
   end

endmodule

@@ src/fat_datetime_to_unix_seconds.sv @@
// exFAT date/time word to Unix seconds and nanoseconds, three-stage pipeline.
// Uses fdt_pkg, fdt_day_count and the assertion macro header.
// An accepted req beat passes the stage 1, 2 and 3 registers to rsp_tvalid.
// Throughput: one beat per cycle while rsp_tready is high; stages load when
//   empty or draining; a stalled output beat stops intake only in a full pipe.
// Reset: synchronous, active high; clears the stage valid bits only.
`include "fat_datetime_to_unix_seconds_macros.svh"
module fat_datetime_to_unix_seconds (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [31:0] fat_datetime, [39:32] centiseconds,
                                    // [47:40] zone_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [32:0] unix_seconds, [62:33] nanoseconds,
                                    // [63] zero
);

   // ---------------- handshake / stage enables ----------------
   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   assign rdy3       = !v3_ff || rsp_tready;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign rsp_tvalid = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // ---------------- stage 1: field decode, day count ----------------
   logic [31:0] fat_datetime;
   logic [7:0]  centiseconds;
   logic [7:0]  zone_byte;

   assign fat_datetime = req_tdata[31:0];
   assign centiseconds = req_tdata[39:32];
   assign zone_byte    = req_tdata[47:40];

   logic [15:0]       days_in;
   logic [1:0]        cs_q_in;
   logic [6:0]        cs_r_in;
   logic signed [7:0] zone_in;
   logic [7:0]        cs_sub;

   fdt_day_count u_day_count (
      .year_i  (fat_datetime[31:25]),
      .month_i (fat_datetime[24:21]),
      .day_i   (fat_datetime[20:16]),
      .days_o  (days_in)
   );

   always_comb begin
      // centiseconds split into whole seconds (0..2) and a remainder
      priority if (centiseconds >= 8'(2 * fdt_pkg::CS_PER_SEC)) begin
         cs_q_in = 2'd2;
         cs_sub  = centiseconds - 8'(2 * fdt_pkg::CS_PER_SEC);
      end else if (centiseconds >= fdt_pkg::CS_PER_SEC) begin
         cs_q_in = 2'd1;
         cs_sub  = centiseconds - fdt_pkg::CS_PER_SEC;
      end else begin
         cs_q_in = 2'd0;
         cs_sub  = centiseconds;
      end
      cs_r_in = cs_sub[6:0];
      // bit 6 clear: positive 0..63, bit 7 ignored; else plain signed byte
      if (!zone_byte[6]) zone_in = $signed({2'b00, zone_byte[5:0]});
      else               zone_in = $signed(zone_byte);
   end

   logic [15:0]       s1_days_ff;
   logic [4:0]        s1_hour_ff;
   logic [5:0]        s1_min_ff;
   logic [4:0]        s1_sec2_ff;
   logic [1:0]        s1_cs_q_ff;
   logic [6:0]        s1_cs_r_ff;
   logic signed [7:0] s1_zone_ff;

   always_ff @(posedge clock) begin
      if (rdy1 && req_tvalid) begin
         s1_days_ff <= days_in;
         s1_hour_ff <= fat_datetime[15:11];
         s1_min_ff  <= fat_datetime[10:5];
         s1_sec2_ff <= fat_datetime[4:0];
         s1_cs_q_ff <= cs_q_in;
         s1_cs_r_ff <= cs_r_in;
         s1_zone_ff <= zone_in;
      end
   end

   // ---------------- stage 2: products ----------------
   logic [32:0]        day_secs_in;
   logic [16:0]        tod_in;
   logic signed [17:0] zone_secs_in;
   logic [29:0]        nanos_in;

   always_comb begin
      day_secs_in  = 33'(s1_days_ff) * 33'(fdt_pkg::SEC_PER_DAY);
      // hours and minutes are not range checked
      tod_in       = 17'(s1_hour_ff) * fdt_pkg::SEC_PER_HOUR
                     + 17'(s1_min_ff) * fdt_pkg::SEC_PER_MIN
                     + {11'b0, s1_sec2_ff, 1'b0};
      zone_secs_in = 18'(s1_zone_ff) * fdt_pkg::ZONE_SEC;
      nanos_in     = 30'(s1_cs_r_ff) * fdt_pkg::NS_PER_CS;
   end

   logic [32:0]        s2_day_secs_ff;
   logic [16:0]        s2_tod_ff;
   logic signed [17:0] s2_zone_secs_ff;
   logic [29:0]        s2_nanos_ff;
   logic [1:0]         s2_cs_q_ff;

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         s2_day_secs_ff  <= day_secs_in;
         s2_tod_ff       <= tod_in;
         s2_zone_secs_ff <= zone_secs_in;
         s2_nanos_ff     <= nanos_in;
         s2_cs_q_ff      <= s1_cs_q_ff;
      end
   end

   // ---------------- stage 3: final sum, output register ----------------
   logic signed [34:0] secs_sum_in;

   always_comb begin
      // result always lands in range, so the 33-bit cut never wraps
      secs_sum_in = $signed({2'b00, s2_day_secs_ff}) + $signed({18'b0, s2_tod_ff})
                    + $signed({33'b0, s2_cs_q_ff}) - 35'(s2_zone_secs_ff);
   end

   logic [32:0] s3_secs_ff;
   logic [29:0] s3_nanos_ff;

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         s3_secs_ff  <= secs_sum_in[32:0];
         s3_nanos_ff <= s2_nanos_ff;
      end
   end

   assign rsp_tdata = {1'b0, s3_nanos_ff, s3_secs_ff};

   // ---------------- assertions ----------------
   // a full, stalled pipe must refuse new beats
   `FDT_ASSERT_NOW(a_full_stall, clock, reset,
      v1_ff && v2_ff && v3_ff && !rsp_tready, !req_tready)
   // a stage that cannot drain keeps its beat
   `FDT_ASSERT_NEXT(a_s1_hold, clock, reset, v1_ff && !rdy2, v1_ff)
   // remainder stays below one second
   `FDT_ASSERT_NOW(a_nanos_range, clock, reset, v3_ff, s3_nanos_ff <= 30'd990000000)
   // earliest encodable time falls late in 1979, still above this floor
   `FDT_ASSERT_NOW(a_secs_floor, clock, reset, v3_ff, s3_secs_ff >= 33'd315000000)

endmodule

@@ dv/fat_datetime_to_unix_seconds_test.sv @@
// Self-checking testbench for fat_datetime_to_unix_seconds: directed calendar and zone corners,
// then randomized timestamps, with random stalls on both stream sides. Needs only the RTL.
`timescale 1ns / 1ps

module fat_datetime_to_unix_seconds_test;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned RANDOM_STAMPS = 1900;
   localparam int unsigned HOLD_AT_RESULT = 400;   // result count that starts the long hold
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned MAX_REPORTS = 10;
   localparam longint EPOCH_GAP_DAYS = 365 * 10 + 2;   // 1970 to 1980
   localparam longint LAST_LEAPLESS_YEAR = 120;        // 2100 has no leap day

   // days before the first of each month, indexed by the raw 4-bit month
   localparam longint DAYS_BEFORE[16] = '{0, 0, 31, 59, 90, 120, 151, 181,
                                           212, 243, 273, 304, 334, 0, 0, 0};

   typedef struct packed {
      logic [29:0] nanoseconds;
      logic [32:0] unix_seconds;
   } unix_time_type;

   typedef struct {
      logic [47:0] data;          // {zone_byte, centiseconds, fat_datetime}
      int unsigned gap;           // idle cycles before this beat is offered
      bit          drain_first;   // hold this beat until every result is back
   } stamp_beat_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // [31:0] fat_datetime, [39:32] centiseconds, [47:40] zone_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // [32:0] unix_seconds, [62:33] nanoseconds, [63] zero

   stamp_beat_type stamp_queue[$];
   unix_time_type  expected_times[$];

   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned beats_sent = 0;
   int unsigned results_seen = 0;
   int unsigned input_stall_cycles = 0;
   int unsigned directed_count = 0;
   int unsigned idle_left = 0;
   bit          gap_armed = 1'b0;
   bit          offer;
   int unsigned rx_wait = 0;
   int unsigned rx_hold = 0;

   fat_datetime_to_unix_seconds i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Expected Unix time of one timestamp beat.
   function automatic unix_time_type unix_time_of(input logic [31:0] stamp,
                                                  input logic [7:0] centis,
                                                  input logic [7:0] zone);
      longint year, month, day, leap_days, secs, quarters;
      unix_time_type t;
      year = longint'(stamp[31:25]);
      month = longint'(stamp[24:21]);
      day = longint'(stamp[20:16]);
      if (month == 0) month = 1;
      if (day == 0) day = 1;
      day = day - 1;
      // leap days in the years before this one, counted from 1980
      leap_days = (year + 3) / 4;
      if (year > LAST_LEAPLESS_YEAR) leap_days = leap_days - 1;
      // months 13..15 count as past February here
      if (year % 4 == 0 && year != LAST_LEAPLESS_YEAR && month > 2)
         leap_days = leap_days + 1;
      secs = longint'(stamp[4:0]) * 2 + longint'(stamp[10:5]) * 60
             + longint'(stamp[15:11]) * 3600;
      secs = secs + (year * 365 + leap_days + DAYS_BEFORE[month] + day + EPOCH_GAP_DAYS) * 86400;
      // bit 6 clear: positive 0..63 whatever bit 7 says; set: signed byte
      if (!zone[6]) quarters = longint'(zone[5:0]);
      else quarters = longint'($signed(zone));
      secs = secs - quarters * 15 * 60;
      secs = secs + longint'(centis) / 100;
      t.unix_seconds = secs[32:0];
      t.nanoseconds = 30'((longint'(centis) % 100) * 10000000);
      return t;
   endfunction

   function automatic logic [31:0] make_stamp(input int unsigned year, input int unsigned month,
                                              input int unsigned day, input int unsigned hour,
                                              input int unsigned minute,
                                              input int unsigned half_sec);
      return {7'(year), 4'(month), 5'(day), 5'(hour), 6'(minute), 5'(half_sec)};
   endfunction

   function automatic void add_stamp(input logic [31:0] stamp, input logic [7:0] centis,
                                     input logic [7:0] zone, input int unsigned gap,
                                     input bit drain_first);
      stamp_beat_type b;
      b.data = {zone, centis, stamp};
      b.gap = gap;
      b.drain_first = drain_first;
      stamp_queue.push_back(b);
   endfunction

   function automatic void note_mismatch(input string what, input longint want,
                                         input longint got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch at result %0d: %s expected %0d got %0d",
                  results_seen, what, want, got);
   endfunction

   // Driver: offers queued beats, idling per beat; drain_first beats wait for an empty pipe.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_armed = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_times.push_back(unix_time_of(req_tdata[31:0], req_tdata[39:32],
                                                  req_tdata[47:40]));
            beats_sent++;
         end
         if (req_tvalid && !req_tready) input_stall_cycles++;
         if (!req_tvalid || req_tready) begin
            offer = 1'b0;
            if (stamp_queue.size() != 0) begin
               if (!gap_armed) begin
                  idle_left = stamp_queue[0].gap;
                  gap_armed = 1'b1;
               end
               if (idle_left != 0) begin
                  idle_left--;
               end else if (!stamp_queue[0].drain_first || expected_times.size() == 0) begin
                  offer = 1'b1;
                  req_tdata <= stamp_queue[0].data;
                  stamp_queue.delete(0);
                  gap_armed = 1'b0;
               end
            end
            req_tvalid <= offer;
         end
      end
   end

   // Monitor: checks each result beat and throttles rsp_tready.
   always @(posedge clock) begin
      unix_time_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait = 0;
         rx_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_times.size() == 0) begin
               note_mismatch("unexpected result, unix_seconds", 0, longint'(rsp_tdata[32:0]));
            end else begin
               want = expected_times.pop_front();
               if (rsp_tdata[32:0] !== want.unix_seconds)
                  note_mismatch("unix_seconds", longint'(want.unix_seconds),
                                longint'(rsp_tdata[32:0]));
               if (rsp_tdata[62:33] !== want.nanoseconds)
                  note_mismatch("nanoseconds", longint'(want.nanoseconds),
                                longint'(rsp_tdata[62:33]));
               if (rsp_tdata[63] !== 1'b0)
                  note_mismatch("pad bit", 0, longint'(rsp_tdata[63]));
            end
            // long hold lets the pipe fill while the driver keeps offering
            if (results_seen == HOLD_AT_RESULT) rx_hold = HOLD_CYCLES;
            // every third stretch of 300 results runs without random waits
            if ((results_seen / 300) % 3 == 1) rx_wait = 0;
            else rx_wait = $urandom_range(0, 15);
         end
         if (rx_hold != 0) begin
            rx_hold--;
            rsp_tready <= 1'b0;
         end else if (rx_wait != 0) begin
            rx_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_times.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [31:0] stamp;
      logic [7:0]  centis;
      int unsigned gap;

      // directed corners: epoch year, all-ones, the 2100 rule, leap edges,
      // months 13..15, out-of-range time fields, zone encodings, centisecond carry
      add_stamp(32'h0000_0000, 8'd0, 8'h00, 0, 1'b0);
      add_stamp(32'hffff_ffff, 8'd255, 8'hff, 0, 1'b0);
      add_stamp(make_stamp(120, 2, 28, 23, 59, 29), 8'd99, 8'h00, 0, 1'b0);
      add_stamp(make_stamp(120, 3, 1, 0, 0, 0), 8'd100, 8'h00, 0, 1'b0);
      add_stamp(make_stamp(119, 12, 31, 12, 30, 15), 8'd0, 8'h3f, 1, 1'b0);
      add_stamp(make_stamp(121, 1, 1, 0, 0, 0), 8'd199, 8'hbf, 0, 1'b0);
      add_stamp(make_stamp(124, 3, 1, 0, 0, 0), 8'd200, 8'h40, 3, 1'b0);
      add_stamp(make_stamp(0, 2, 29, 6, 7, 8), 8'd1, 8'h7f, 0, 1'b0);
      add_stamp(make_stamp(0, 3, 1, 0, 0, 0), 8'd50, 8'hc0, 0, 1'b0);
      add_stamp(make_stamp(4, 2, 29, 0, 0, 0), 8'd0, 8'hff, 2, 1'b0);
      add_stamp(make_stamp(4, 13, 10, 1, 1, 1), 8'd0, 8'h80, 0, 1'b0);
      add_stamp(make_stamp(8, 14, 0, 2, 2, 2), 8'd0, 8'h01, 0, 1'b0);
      add_stamp(make_stamp(120, 15, 31, 3, 3, 3), 8'd0, 8'hc1, 0, 1'b0);
      add_stamp(make_stamp(127, 12, 31, 31, 63, 31), 8'd255, 8'h7f, 0, 1'b0);
      add_stamp(make_stamp(127, 0, 0, 0, 0, 0), 8'd0, 8'hc0, 5, 1'b0);
      add_stamp(make_stamp(45, 0, 15, 24, 60, 30), 8'd101, 8'h20, 0, 1'b0);
      add_stamp(make_stamp(46, 7, 0, 0, 0, 0), 8'd0, 8'ha0, 0, 1'b0);
      add_stamp(make_stamp(1, 1, 1, 0, 0, 0), 8'd0, 8'h00, 0, 1'b0);
      add_stamp(make_stamp(3, 12, 31, 23, 59, 29), 8'd99, 8'hfe, 0, 1'b0);
      add_stamp(make_stamp(116, 2, 29, 0, 0, 0), 8'd0, 8'h7e, 0, 1'b0);
      directed_count = stamp_queue.size();

      for (int unsigned n = 0; n < RANDOM_STAMPS; n++) begin
         if ($urandom_range(0, 9) < 7) begin
            // plausible dates, with the end of the range weighted for the 2100 rule
            stamp = make_stamp(($urandom_range(0, 3) == 0) ? $urandom_range(112, 127)
                                                         : $urandom_range(0, 127),
                               $urandom_range(1, 12), $urandom_range(1, 31),
                               $urandom_range(0, 23), $urandom_range(0, 59),
                               $urandom_range(0, 29));
            centis = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 99))
                                                 : 8'($urandom_range(0, 255));
         end else begin
            stamp = $urandom;
            centis = 8'($urandom);
         end
         // idle-free stretches every fourth block of 200 beats
         if ((n / 200) % 4 == 0 || $urandom_range(0, 1) == 0) gap = 0;
         else gap = $urandom_range(0, 15);
         add_stamp(stamp, centis, 8'($urandom), gap, n == 0 || n == 1000);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (stamp_queue.size() != 0 || req_tvalid || expected_times.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("checked %0d conversions: %0d directed corners, %0d random stamps",
               results_seen, directed_count, beats_sent - directed_count);
      $display("input held off on %0d cycles; %0d mismatches", input_stall_cycles, mismatches);
      if (mismatches == 0 && expected_times.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
